// File: rtl/scg_pkg.sv
`timescale 1ns / 1ps

package scg_pkg;

    // grid store geometry
    localparam int MAX_COLS = 64;
    localparam int MAX_ROWS = 64;
    localparam int DEPTH    = MAX_COLS * MAX_ROWS;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int ADDR_W   = $clog2(DEPTH);

    // fixed field widths
    localparam int SIZE_W  = 7;
    localparam int CELL_W  = 6;
    localparam int COST_W  = 8;
    localparam int SHIFT_W = 16;
    localparam int ORG_W   = 32;
    localparam int CFG_IDX_W = 2;

    // width for size limits and counter compares
    localparam int LIM_W = ((SIZE_W > COL_W) ? SIZE_W : COL_W) +
                           ((ROW_W > COL_W) ? ROW_W - COL_W : 0) + 1;
    // width for signed source coordinates
    localparam int SRC_W = ((COL_W > SHIFT_W) ? COL_W : SHIFT_W) +
                           ((ROW_W > COL_W) ? ROW_W - COL_W : 0) + 2;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_SHIFT = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEFAULT_COST  = 2'd0,
        CFG_WIDTH_IN_USE  = 2'd1,
        CFG_HEIGHT_IN_USE = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        SW_IDLE,
        SW_RUN,
        SW_DRAIN
    } t_sw_state;

    typedef enum logic [1:0] {
        KIND_INIT,
        KIND_CLEAR,
        KIND_SHIFT
    } t_sw_kind;

    // one cycle of memory traffic
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic              wr_use_q;
        logic [COST_W-1:0] wr_value;
    } t_mem_req;

    // request to start a sweep over the grid
    typedef struct packed {
        logic                      start;
        logic                      is_shift;
        logic signed [SHIFT_W-1:0] dx;
        logic signed [SHIFT_W-1:0] dy;
    } t_sweep_cmd;

    // size in use, capped at the store size
    function automatic logic [LIM_W-1:0] used_limit(input logic [SIZE_W-1:0] size,
                                                    input int maxv);
        logic [LIM_W-1:0] res;
        if (int'(size) > maxv) begin
            res = LIM_W'(maxv);
        end else begin
            res = LIM_W'(size);
        end
        return res;
    endfunction

    // row-major store address of a cell
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] y,
                                                   input logic [COL_W-1:0] x);
        return ADDR_W'(ADDR_W'(y) * ADDR_W'(MAX_COLS) + ADDR_W'(x));
    endfunction

endpackage

// File: rtl/scg_store.sv
`timescale 1ns / 1ps

module scg_store (
    input  logic                 i_clk,
    input  scg_pkg::t_mem_req    i_req,
    output logic [scg_pkg::COST_W-1:0] o_q
);
    import scg_pkg::*;

    logic [COST_W-1:0] r_mem [DEPTH];
    logic [COST_W-1:0] r_q;

    // single write port, registered read port; write-back may take the last read
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_use_q ? r_q : i_req.wr_value;
        end
        if (i_req.rd_en) begin
            r_q <= r_mem[i_req.rd_addr];
        end
    end

    assign o_q = r_q;

endmodule

// File: rtl/scg_sweep.sv
`timescale 1ns / 1ps

module scg_sweep (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  scg_pkg::t_sweep_cmd         i_cmd,
    input  logic [scg_pkg::LIM_W-1:0]   i_cols,
    input  logic [scg_pkg::LIM_W-1:0]   i_rows,
    input  logic [scg_pkg::COST_W-1:0]  i_default_cost,
    output logic                        o_busy,
    output logic                        o_done,
    output scg_pkg::t_mem_req           o_req
);
    import scg_pkg::*;

    t_sw_state r_state, n_state;
    t_sw_kind  r_kind;

    logic [COL_W-1:0]          r_x;
    logic [ROW_W-1:0]          r_y;
    logic [LIM_W-1:0]          r_lim_cols;
    logic [LIM_W-1:0]          r_lim_rows;
    logic                      r_desc;
    logic signed [SHIFT_W-1:0] r_dx;
    logic signed [SHIFT_W-1:0] r_dy;

    // write-back stage
    logic              r_wb_valid;
    logic [ADDR_W-1:0] r_wb_addr;
    logic              r_wb_use_q;
    logic [COST_W-1:0] r_wb_value;

    logic             row_end;
    logic             last_cell;
    logic             zero_size;
    logic [SRC_W-1:0] sx;
    logic [SRC_W-1:0] sy;
    logic             src_ok;

    // position tests for the scan order
    always_comb begin
        if (r_desc) begin
            row_end   = (r_x == '0);
            last_cell = row_end && (r_y == '0);
        end else begin
            row_end   = (LIM_W'(r_x) == r_lim_cols - LIM_W'(1));
            last_cell = row_end && (LIM_W'(r_y) == r_lim_rows - LIM_W'(1));
        end
        zero_size = (i_cols == '0) || (i_rows == '0);
    end

    // source cell of a shift and whether it lies inside the size in use
    always_comb begin
        sx = SRC_W'(r_x) + SRC_W'(r_dx);
        sy = SRC_W'(r_y) + SRC_W'(r_dy);
        src_ok = !sx[SRC_W-1] && (sx < SRC_W'(r_lim_cols)) &&
                 !sy[SRC_W-1] && (sy < SRC_W'(r_lim_rows));
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            SW_IDLE: begin
                if (i_cmd.start) begin
                    n_state = zero_size ? SW_DRAIN : SW_RUN;
                end
            end
            SW_RUN: begin
                if (last_cell) begin
                    n_state = SW_DRAIN;
                end
            end
            SW_DRAIN: begin
                n_state = SW_IDLE;
            end
            default: begin
                n_state = SW_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_busy = (r_state != SW_IDLE);
        o_done = (r_state == SW_DRAIN) && (r_kind != KIND_INIT);
        o_req.rd_en    = (r_state == SW_RUN) && (r_kind == KIND_SHIFT) && src_ok;
        o_req.rd_addr  = cell_addr(sy[ROW_W-1:0], sx[COL_W-1:0]);
        o_req.wr_en    = r_wb_valid;
        o_req.wr_addr  = r_wb_addr;
        o_req.wr_use_q = r_wb_use_q;
        o_req.wr_value = r_wb_value;
    end

    // control state; reset starts the clearing pass over the whole store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= SW_RUN;
            r_kind     <= KIND_INIT;
            r_x        <= '0;
            r_y        <= '0;
            r_lim_cols <= LIM_W'(MAX_COLS);
            r_lim_rows <= LIM_W'(MAX_ROWS);
            r_desc     <= 1'b0;
            r_dx       <= '0;
            r_dy       <= '0;
            r_wb_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_wb_valid <= (r_state == SW_RUN);
            if (r_state == SW_IDLE && i_cmd.start) begin
                r_kind     <= i_cmd.is_shift ? KIND_SHIFT : KIND_CLEAR;
                r_lim_cols <= i_cols;
                r_lim_rows <= i_rows;
                r_dx       <= i_cmd.dx;
                r_dy       <= i_cmd.dy;
                // scan downward when sources sit below their destinations
                if (i_cmd.is_shift && (i_cmd.dy[SHIFT_W-1] ||
                        (i_cmd.dy == '0 && i_cmd.dx[SHIFT_W-1]))) begin
                    r_desc <= 1'b1;
                    r_x    <= COL_W'(i_cols - LIM_W'(1));
                    r_y    <= ROW_W'(i_rows - LIM_W'(1));
                end else begin
                    r_desc <= 1'b0;
                    r_x    <= '0;
                    r_y    <= '0;
                end
            end else if (r_state == SW_RUN && !last_cell) begin
                if (r_desc) begin
                    if (row_end) begin
                        r_x <= COL_W'(r_lim_cols - LIM_W'(1));
                        r_y <= r_y - ROW_W'(1);
                    end else begin
                        r_x <= r_x - COL_W'(1);
                    end
                end else begin
                    if (row_end) begin
                        r_x <= '0;
                        r_y <= r_y + ROW_W'(1);
                    end else begin
                        r_x <= r_x + COL_W'(1);
                    end
                end
            end
        end
    end

    // write-back payload, used in the cycle after the source read
    always_ff @(posedge i_clk) begin
        r_wb_addr  <= cell_addr(r_y, r_x);
        r_wb_use_q <= (r_kind == KIND_SHIFT) && src_ok;
        r_wb_value <= (r_kind == KIND_INIT) ? '0 : i_default_cost;
    end

endmodule

// File: rtl/scrolling_cost_grid.sv
`timescale 1ns / 1ps
// Scrolling cost grid: a 64 x 64 store of byte costs with read, write,
// shift and clear commands, one result item per input item.
// Input channel: i_in_valid / o_in_ready carry cmd, cell, cost and shift.
// Output channel: o_out_valid / i_out_ready carry read cost, range flag
// and the window origin after the item.
// Configuration: i_cfg_we writes default cost, width or height at once;
// write only while no item is in flight.
// Read and write: result in the cycle after accept, one item per cycle
// while the output is not stalled. Clear: one cell written per cycle.
// Shift: at most one read and one write-back per cell on the
// one-read one-write store; the scan runs up or down so no source is
// overwritten before it is read. Width or height of zero gives a result
// with no cell written.
// Reset: origin and registers return to reset values and a clearing pass
// zeroes all 4096 cells; no item is accepted meanwhile.
// A stalled result holds in the output register; the next item is taken
// in the same cycle that the result leaves.
module scrolling_cost_grid (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [scg_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [scg_pkg::COST_W-1:0]           i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [1:0]                           i_cmd,
    input  logic [scg_pkg::CELL_W-1:0]           i_cell_x,
    input  logic [scg_pkg::CELL_W-1:0]           i_cell_y,
    input  logic [scg_pkg::COST_W-1:0]           i_new_cost,
    input  logic signed [scg_pkg::SHIFT_W-1:0]   i_shift_x,
    input  logic signed [scg_pkg::SHIFT_W-1:0]   i_shift_y,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [scg_pkg::COST_W-1:0]           o_read_cost,
    output logic                                 o_out_of_range,
    output logic signed [scg_pkg::ORG_W-1:0]     o_origin_cell_x,
    output logic signed [scg_pkg::ORG_W-1:0]     o_origin_cell_y
);
    import scg_pkg::*;

    logic [COST_W-1:0] r_default_cost;
    logic [SIZE_W-1:0] r_width;
    logic [SIZE_W-1:0] r_height;

    logic signed [ORG_W-1:0] r_org_col;
    logic signed [ORG_W-1:0] r_org_row;

    logic r_out_valid;
    logic r_out_oor;
    logic r_out_is_read;

    t_cmd             cmd;
    logic             accept;
    logic             in_grid;
    logic [LIM_W-1:0] cols;
    logic [LIM_W-1:0] rows;
    logic             sw_busy;
    logic             sw_done;
    t_sweep_cmd       sw_cmd;
    t_mem_req         sw_req;
    t_mem_req         acc_req;
    t_mem_req         mem_req;
    logic [COST_W-1:0] mem_q;

    // decode and range check
    always_comb begin
        cmd    = t_cmd'(i_cmd);
        cols   = used_limit(r_width, MAX_COLS);
        rows   = used_limit(r_height, MAX_ROWS);
        in_grid = (LIM_W'(i_cell_x) < cols) && (LIM_W'(i_cell_y) < rows);
        o_in_ready = !sw_busy && (!r_out_valid || i_out_ready);
        accept = i_in_valid && o_in_ready;
    end

    // sweep request for shift and clear
    always_comb begin
        sw_cmd.start    = accept && (cmd == CMD_SHIFT || cmd == CMD_CLEAR);
        sw_cmd.is_shift = (cmd == CMD_SHIFT);
        sw_cmd.dx       = i_shift_x;
        sw_cmd.dy       = i_shift_y;
    end

    // single cell access, store port handed to the sweep while it runs
    always_comb begin
        acc_req.rd_en    = accept && (cmd == CMD_READ) && in_grid;
        acc_req.rd_addr  = cell_addr(ROW_W'(i_cell_y), COL_W'(i_cell_x));
        acc_req.wr_en    = accept && (cmd == CMD_WRITE) && in_grid;
        acc_req.wr_addr  = cell_addr(ROW_W'(i_cell_y), COL_W'(i_cell_x));
        acc_req.wr_use_q = 1'b0;
        acc_req.wr_value = i_new_cost;
        mem_req = sw_busy ? sw_req : acc_req;
    end

    scg_sweep u_sweep (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (sw_cmd),
        .i_cols         (cols),
        .i_rows         (rows),
        .i_default_cost (r_default_cost),
        .o_busy         (sw_busy),
        .o_done         (sw_done),
        .o_req          (sw_req)
    );

    scg_store u_store (
        .i_clk (i_clk),
        .i_req (mem_req),
        .o_q   (mem_q)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_cost <= '0;
            r_width        <= SIZE_W'(64);
            r_height       <= SIZE_W'(64);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_DEFAULT_COST:  r_default_cost <= i_cfg_data;
                CFG_WIDTH_IN_USE:  r_width        <= i_cfg_data[SIZE_W-1:0];
                CFG_HEIGHT_IN_USE: r_height       <= i_cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // window origin, wrapping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_col <= '0;
            r_org_row <= '0;
        end else if (accept && cmd == CMD_SHIFT) begin
            r_org_col <= r_org_col + ORG_W'(i_shift_x);
            r_org_row <= r_org_row + ORG_W'(i_shift_y);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_out_oor     <= 1'b0;
            r_out_is_read <= 1'b0;
        end else if (accept && (cmd == CMD_READ || cmd == CMD_WRITE)) begin
            r_out_valid   <= 1'b1;
            r_out_oor     <= !in_grid;
            r_out_is_read <= (cmd == CMD_READ) && in_grid;
        end else if (sw_done) begin
            r_out_valid   <= 1'b1;
            r_out_oor     <= 1'b0;
            r_out_is_read <= 1'b0;
        end else if (i_out_ready) begin
            r_out_valid   <= 1'b0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_read_cost     = r_out_is_read ? mem_q : '0;
    assign o_out_of_range  = r_out_oor;
    assign o_origin_cell_x = r_org_col;
    assign o_origin_cell_y = r_org_row;

    // a sweep never ends on top of an undelivered result
    a_done_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sw_done |-> !r_out_valid)
        else $error("sweep finished while a result was pending");

    // a read or write gives its result on the next cycle
    a_access_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (cmd == CMD_READ || cmd == CMD_WRITE)) |=> r_out_valid)
        else $error("access result missing");

    // a shift moves the origin column by its x offset
    a_origin_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && cmd == CMD_SHIFT) |=>
        (r_org_col == $past(r_org_col) + $past(ORG_W'(i_shift_x))))
        else $error("origin column not advanced by shift");

    // a sweep request makes the sweep busy, so no item is taken while it owns the store
    a_busy_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sw_cmd.start |=> sw_busy)
        else $error("sweep did not start");

endmodule
